// ----- rtl/fdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsa_pkg
// Shared types, constants and ALU functions for the Forth data stack.
// ----------------------------------------------------------------------------
package fdsa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CELL_WIDTH  = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 2);
  localparam int CMP_W       = (CELL_WIDTH > CNT_W) ? CELL_WIDTH : CNT_W;
  localparam int DIV_STEP_W  = $clog2(CELL_WIDTH + 1);

  typedef logic [CELL_WIDTH-1:0] cell_t;

  typedef enum logic [5:0] {
    OP_LIT    = 6'd0,  OP_DROP   = 6'd1,  OP_DUP    = 6'd2,  OP_QDUP   = 6'd3,
    OP_OVER   = 6'd4,  OP_SWAP   = 6'd5,  OP_ROT    = 6'd6,  OP_NROT   = 6'd7,
    OP_PICK   = 6'd8,  OP_ROLL   = 6'd9,  OP_DEPTH  = 6'd10, OP_ADD    = 6'd11,
    OP_SUB    = 6'd12, OP_MUL    = 6'd13, OP_DIV    = 6'd14, OP_MOD    = 6'd15,
    OP_DIVMOD = 6'd16, OP_INC1   = 6'd17, OP_DEC1   = 6'd18, OP_INC2   = 6'd19,
    OP_DEC2   = 6'd20, OP_SHL    = 6'd21, OP_SHR    = 6'd22, OP_INC4   = 6'd23,
    OP_DEC4   = 6'd24, OP_MIN    = 6'd25, OP_MAX    = 6'd26, OP_ABS    = 6'd27,
    OP_NEG    = 6'd28, OP_LT     = 6'd29, OP_LE     = 6'd30, OP_NE     = 6'd31,
    OP_EQ     = 6'd32, OP_GT     = 6'd33, OP_GE     = 6'd34, OP_ZLT    = 6'd35,
    OP_ZEQ    = 6'd36, OP_ZGT    = 6'd37, OP_AND    = 6'd38, OP_OR     = 6'd39,
    OP_XOR    = 6'd40, OP_NOT    = 6'd41
  } func_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_UNDER = 2'd1,
    ERR_OVER  = 2'd2,
    ERR_DIV0  = 2'd3
  } err_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SCAN, ST_DIV, ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD, CELL_PUSH, CELL_POP, CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     scan_load;
    logic     scan_shift;
  } cell_ctl_t;

  function automatic cell_t flag(input logic c);
    flag = c ? '1 : '0;
  endfunction

  function automatic cell_t alu_bin(input func_t f, input cell_t a, input cell_t b);
    logic lt_ab, lt_ba;
    lt_ab = $signed(a) < $signed(b);
    lt_ba = $signed(b) < $signed(a);
    case (f)
      OP_ADD:  alu_bin = a + b;
      OP_SUB:  alu_bin = a - b;
      OP_MUL:  alu_bin = a * b;
      OP_MIN:  alu_bin = lt_ab ? a : b;
      OP_MAX:  alu_bin = lt_ba ? a : b;
      OP_LT:   alu_bin = flag(lt_ab);
      OP_LE:   alu_bin = flag(!lt_ba);
      OP_NE:   alu_bin = flag(a != b);
      OP_EQ:   alu_bin = flag(a == b);
      OP_GT:   alu_bin = flag(lt_ba);
      OP_GE:   alu_bin = flag(!lt_ab);
      OP_AND:  alu_bin = a & b;
      OP_OR:   alu_bin = a | b;
      default: alu_bin = a ^ b;
    endcase
  endfunction

  function automatic cell_t alu_un(input func_t f, input cell_t t);
    case (f)
      OP_INC1: alu_un = t + cell_t'(1);
      OP_DEC1: alu_un = t - cell_t'(1);
      OP_INC2: alu_un = t + cell_t'(2);
      OP_DEC2: alu_un = t - cell_t'(2);
      OP_SHL:  alu_un = {t[CELL_WIDTH-2:0], 1'b0};
      OP_SHR:  alu_un = {t[CELL_WIDTH-1], t[CELL_WIDTH-1:1]};
      OP_INC4: alu_un = t + cell_t'(4);
      OP_DEC4: alu_un = t - cell_t'(4);
      OP_ABS:  alu_un = t[CELL_WIDTH-1] ? cell_t'(-t) : t;
      OP_NEG:  alu_un = -t;
      OP_ZLT:  alu_un = flag(t[CELL_WIDTH-1]);
      OP_ZEQ:  alu_un = flag(t == '0);
      OP_ZGT:  alu_un = flag(t != '0 && !t[CELL_WIDTH-1]);
      default: alu_un = ~t;
    endcase
  endfunction

  function automatic logic [31:0] to_port(input cell_t v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    to_port = w[31:0];
  endfunction

  function automatic cell_t from_port(input logic [31:0] v);
    logic signed [63:0] w;
    w = 64'(signed'(v));
    from_port = w[CELL_WIDTH-1:0];
  endfunction

endpackage

// ----- rtl/fdsa_cell.sv -----
// ----------------------------------------------------------------------------
// fdsa_cell
// One stack cell with its neighbour links and a scan register for pick/roll.
// ----------------------------------------------------------------------------
module fdsa_cell (
  input  logic               clk,
  input  fdsa_pkg::cell_ctl_t ctl,
  input  fdsa_pkg::cell_t    upper,
  input  fdsa_pkg::cell_t    lower,
  input  fdsa_pkg::cell_t    ld,
  input  fdsa_pkg::cell_t    scan_in,
  output fdsa_pkg::cell_t    value,
  output fdsa_pkg::cell_t    scan
);
  import fdsa_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_PUSH: value <= upper;
      CELL_POP:  value <= lower;
      CELL_LOAD: value <= ld;
      default:   value <= value;
    endcase
    if (ctl.scan_load) begin
      scan <= value;
    end else if (ctl.scan_shift) begin
      scan <= scan_in;
    end
  end

endmodule

// ----- rtl/fdsa_div.sv -----
// ----------------------------------------------------------------------------
// fdsa_div
// Signed restoring divider, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module fdsa_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  fdsa_pkg::cell_t dividend,
  input  fdsa_pkg::cell_t divisor,
  output logic            done,
  output fdsa_pkg::cell_t quot,
  output fdsa_pkg::cell_t rem
);
  import fdsa_pkg::*;

  logic                  running;
  logic [DIV_STEP_W-1:0] steps;
  cell_t                 q;
  cell_t                 r;
  cell_t                 d;
  logic                  neg_q;
  logic                  neg_r;
  logic [CELL_WIDTH:0]   shifted;
  logic [CELL_WIDTH:0]   trial;

  assign shifted = {r, q[CELL_WIDTH-1]};
  assign trial   = shifted - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= DIV_STEP_W'(CELL_WIDTH);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == DIV_STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q     <= dividend[CELL_WIDTH-1] ? cell_t'(-dividend) : dividend;
      d     <= divisor[CELL_WIDTH-1] ? cell_t'(-divisor) : divisor;
      r     <= '0;
      neg_q <= dividend[CELL_WIDTH-1] ^ divisor[CELL_WIDTH-1];
      neg_r <= dividend[CELL_WIDTH-1];
    end else if (running) begin
      if (!trial[CELL_WIDTH]) begin
        r <= trial[CELL_WIDTH-1:0];
      end else begin
        r <= shifted[CELL_WIDTH-1:0];
      end
      q <= {q[CELL_WIDTH-2:0], ~trial[CELL_WIDTH]};
    end
  end

  assign quot = neg_q ? cell_t'(-q) : q;
  assign rem  = neg_r ? cell_t'(-r) : r;

endmodule

// ----- rtl/forth_data_stack_alu.sv -----
// ----------------------------------------------------------------------------
// forth_data_stack_alu
// Forth data stack: top-of-stack register over a chain of cells, with ALU.
// ----------------------------------------------------------------------------
// Usage: raise start with func and literal; the word is taken at a clock
// edge where start is high and busy is low. One result per word: done is
// high for exactly one cycle with top, second, items and error valid; the
// receiver cannot stall and must take it then.
// Most words pass through the execute state to the done state; busy is low
// in the done cycle, so the next word may already be given there.
// PICK and ROLL first pass through a scan state, in which the scan register
// chain steps one cell per cycle until index n is reached. /, MOD and /MOD
// wait in a divide state for the one-bit-per-cycle divider.
// Refused words (underflow, overflow, bad index, division by zero) leave
// the stack as it was and report a code in error.
// Reset empties the stack and clears the top register; cell contents are
// not cleared and are never shown while unused.
// ----------------------------------------------------------------------------
module forth_data_stack_alu (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [5:0]  func,
  input  logic signed [31:0] literal,
  output logic        busy,
  output logic        done,
  output logic signed [31:0] top,
  output logic signed [31:0] second,
  output logic [6:0]  items,
  output logic [1:0]  error
);
  import fdsa_pkg::*;

  state_t           state, state_next;
  func_t            func_r;
  cell_t            lit_r;
  cell_t            tos, tos_next;
  logic [CNT_W-1:0] depth, depth_next;
  err_t             err, err_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] u_r, u_next;

  cell_t     cell_val [STACK_DEPTH];
  cell_t     scan_val [STACK_DEPTH];
  cell_ctl_t ctl      [STACK_DEPTH];

  cell_op_t op_all;
  logic     scan_load, scan_shift, roll_en, ld0_en, ld1_en, div_start;
  cell_t    ld0, ld1;
  logic     div_done;
  cell_t    div_q, div_r;

  cell_t            s, th;
  logic [CNT_W-1:0] n_m1;
  logic             push_en;
  cell_t            push_val;

  assign s    = cell_val[0];
  assign th   = cell_val[1];
  assign n_m1 = depth - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tos   <= '0;
      depth <= '0;
      err   <= ERR_OK;
      cnt   <= '0;
      u_r   <= '0;
    end else begin
      state <= state_next;
      tos   <= tos_next;
      depth <= depth_next;
      err   <= err_next;
      cnt   <= cnt_next;
      u_r   <= u_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      func_r <= func_t'(func);
      lit_r  <= from_port(literal);
    end
  end

  always_comb begin
    state_next = state;
    tos_next   = tos;
    depth_next = depth;
    err_next   = err;
    cnt_next   = cnt;
    u_next     = u_r;
    op_all     = CELL_HOLD;
    scan_load  = 1'b0;
    scan_shift = 1'b0;
    roll_en    = 1'b0;
    ld0_en     = 1'b0;
    ld1_en     = 1'b0;
    ld0        = tos;
    ld1        = s;
    div_start  = 1'b0;
    push_en    = 1'b0;
    push_val   = tos;
    unique case (state)
      ST_IDLE, ST_FIN: begin
        state_next = start ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_next = ST_FIN;
        err_next   = ERR_OK;
        case (func_r)
          OP_LIT, OP_DUP, OP_OVER, OP_DEPTH: begin
            if ((func_r == OP_DUP && depth < CNT_W'(1)) ||
                (func_r == OP_OVER && depth < CNT_W'(2))) begin
              err_next = ERR_UNDER;
            end else if (depth > CNT_W'(STACK_DEPTH)) begin
              err_next = ERR_OVER;
            end else begin
              push_en = 1'b1;
              case (func_r)
                OP_LIT:  push_val = lit_r;
                OP_OVER: push_val = s;
                OP_DEPTH: push_val = cell_t'(depth);
                default: push_val = tos;
              endcase
            end
          end
          OP_DROP: begin
            if (depth < CNT_W'(1)) begin
              err_next = ERR_UNDER;
            end else begin
              tos_next   = (depth >= CNT_W'(2)) ? s : '0;
              op_all     = CELL_POP;
              depth_next = n_m1;
            end
          end
          OP_QDUP: begin
            if (depth < CNT_W'(1)) begin
              err_next = ERR_UNDER;
            end else if (tos != '0) begin
              if (depth > CNT_W'(STACK_DEPTH)) begin
                err_next = ERR_OVER;
              end else begin
                push_en = 1'b1;
              end
            end
          end
          OP_SWAP: begin
            if (depth < CNT_W'(2)) begin
              err_next = ERR_UNDER;
            end else begin
              tos_next = s;
              ld0_en   = 1'b1;
            end
          end
          OP_ROT, OP_NROT: begin
            if (depth < CNT_W'(3)) begin
              err_next = ERR_UNDER;
            end else begin
              ld0_en = 1'b1;
              ld1_en = 1'b1;
              if (func_r == OP_ROT) begin
                ld0      = tos;
                ld1      = s;
                tos_next = th;
              end else begin
                ld0      = th;
                ld1      = tos;
                tos_next = s;
              end
            end
          end
          OP_PICK, OP_ROLL: begin
            if (depth < CNT_W'(1) || tos[CELL_WIDTH-1] ||
                CMP_W'(tos) >= CMP_W'(n_m1)) begin
              err_next = ERR_UNDER;
            end else begin
              scan_load  = 1'b1;
              cnt_next   = tos[IDX_W-1:0];
              u_next     = tos[IDX_W-1:0];
              state_next = ST_SCAN;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DIVMOD, OP_MIN, OP_MAX,
          OP_LT, OP_LE, OP_NE, OP_EQ, OP_GT, OP_GE, OP_AND, OP_OR, OP_XOR: begin
            if (depth < CNT_W'(2)) begin
              err_next = ERR_UNDER;
            end else if (func_r == OP_DIV || func_r == OP_MOD ||
                         func_r == OP_DIVMOD) begin
              if (tos == '0) begin
                err_next = ERR_DIV0;
              end else begin
                div_start  = 1'b1;
                state_next = ST_DIV;
              end
            end else begin
              tos_next   = alu_bin(func_r, s, tos);
              op_all     = CELL_POP;
              depth_next = n_m1;
            end
          end
          OP_INC1, OP_DEC1, OP_INC2, OP_DEC2, OP_SHL, OP_SHR, OP_INC4, OP_DEC4,
          OP_ABS, OP_NEG, OP_ZLT, OP_ZEQ, OP_ZGT, OP_NOT: begin
            if (depth < CNT_W'(1)) begin
              err_next = ERR_UNDER;
            end else begin
              tos_next = alu_un(func_r, tos);
            end
          end
          default: ;
        endcase
        if (push_en) begin
          op_all     = CELL_PUSH;
          tos_next   = push_val;
          depth_next = depth + 1'b1;
        end
      end
      ST_SCAN: begin
        if (cnt == '0) begin
          tos_next   = scan_val[0];
          state_next = ST_FIN;
          if (func_r == OP_ROLL) begin
            roll_en    = 1'b1;
            depth_next = n_m1;
          end
        end else begin
          scan_shift = 1'b1;
          cnt_next   = cnt - 1'b1;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_FIN;
          if (func_r == OP_DIVMOD) begin
            ld0_en   = 1'b1;
            ld0      = div_r;
            tos_next = div_q;
          end else begin
            tos_next   = (func_r == OP_DIV) ? div_q : div_r;
            op_all     = CELL_POP;
            depth_next = n_m1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    cell_t upper, lower, ld, scan_in;

    always_comb begin
      ctl[k].op         = op_all;
      ctl[k].scan_load  = scan_load;
      ctl[k].scan_shift = scan_shift;
      if (roll_en) begin
        ctl[k].op = (IDX_W'(k) >= u_r) ? CELL_POP : CELL_HOLD;
      end
      if ((k == 0 && ld0_en) || (k == 1 && ld1_en)) begin
        ctl[k].op = CELL_LOAD;
      end
    end

    if (k == 0) begin : g_first
      assign upper = tos;
      assign ld    = ld0;
    end else begin : g_rest
      assign upper = cell_val[k-1];
      assign ld    = (k == 1) ? ld1 : '0;
    end

    if (k == STACK_DEPTH - 1) begin : g_last
      assign lower   = '0;
      assign scan_in = '0;
    end else begin : g_mid
      assign lower   = cell_val[k+1];
      assign scan_in = scan_val[k+1];
    end

    fdsa_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[k]),
      .upper   (upper),
      .lower   (lower),
      .ld      (ld),
      .scan_in (scan_in),
      .value   (cell_val[k]),
      .scan    (scan_val[k])
    );
  end

  fdsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s),
    .divisor  (tos),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  assign busy   = (state != ST_IDLE) && (state != ST_FIN);
  assign done   = (state == ST_FIN);
  assign top    = (depth >= CNT_W'(1)) ? to_port(tos) : '0;
  assign second = (depth >= CNT_W'(2)) ? to_port(s) : '0;
  assign items  = 7'(depth);
  assign error  = err;

endmodule

// ----- tb/sv/forth_data_stack_alu_tb.sv -----
// ----------------------------------------------------------------------------
// forth_data_stack_alu_tb
// Drives stack, arithmetic and logic words into the Forth data stack, keeps a
// behavioural copy of the stack and checks every done strobe field by field.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fdsa_pkg::*;

  typedef struct {
    logic [5:0]  fn;
    logic [31:0] lit;
  } word_t;

  typedef struct {
    logic [31:0] top;
    logic [31:0] second;
    logic [6:0]  items;
    logic [1:0]  error;
  } stack_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [5:0] func = '0;
  logic signed [31:0] literal = '0;
  logic busy, done;
  logic signed [31:0] top, second;
  logic [6:0] items;
  logic [1:0] error;

  forth_data_stack_alu dut (
    .clk(clk), .rst(rst), .start(start), .func(func), .literal(literal),
    .busy(busy), .done(done), .top(top), .second(second), .items(items),
    .error(error)
  );

  word_t       pending_words[$];
  stack_view_t expected_views[$];
  logic [31:0] model_top;
  logic [31:0] model_cells[64];
  int          model_depth;
  int          mismatches = 0;
  int          words_sent = 0;
  int          views_seen = 0;
  int          err_seen[4] = '{0, 0, 0, 0};
  int          gap = 0;
  bit          quiet = 1'b0;
  longint      cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic sl(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic logic [31:0] truth(input logic c);
    return c ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  function automatic void trunc_divide(input logic [31:0] a, input logic [31:0] b,
                                       output logic [31:0] q, output logic [31:0] r);
    logic [31:0] ma, mb, qq, rr;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    qq = ma / mb;
    rr = ma % mb;
    q = (a[31] != b[31]) ? -qq : qq;
    r = a[31] ? -rr : rr;
  endfunction

  function automatic void push_cell(input logic [31:0] v);
    if (model_depth >= 1) model_cells[model_depth-1] = model_top;
    model_top = v;
    model_depth++;
  endfunction

  function automatic stack_view_t execute_word(input word_t w);
    stack_view_t v;
    int n, idx;
    logic [31:0] t, a, b, q, r;
    err_t e;
    n = model_depth;
    t = model_top;
    e = ERR_OK;
    case (w.fn)
      OP_LIT, OP_DUP, OP_OVER, OP_DEPTH: begin
        if ((w.fn == OP_DUP && n < 1) || (w.fn == OP_OVER && n < 2)) e = ERR_UNDER;
        else if (n > 64) e = ERR_OVER;
        else if (w.fn == OP_LIT) push_cell(w.lit);
        else if (w.fn == OP_DUP) push_cell(t);
        else if (w.fn == OP_OVER) push_cell(model_cells[n-2]);
        else push_cell(32'(n));
      end
      OP_DROP: begin
        if (n < 1) e = ERR_UNDER;
        else begin
          model_top = (n >= 2) ? model_cells[n-2] : '0;
          model_depth = n - 1;
        end
      end
      OP_QDUP: begin
        if (n < 1) e = ERR_UNDER;
        else if (t != 0) begin
          if (n > 64) e = ERR_OVER;
          else push_cell(t);
        end
      end
      OP_SWAP: begin
        if (n < 2) e = ERR_UNDER;
        else begin
          model_top = model_cells[n-2];
          model_cells[n-2] = t;
        end
      end
      OP_ROT, OP_NROT: begin
        if (n < 3) e = ERR_UNDER;
        else begin
          a = model_cells[n-3];
          b = model_cells[n-2];
          if (w.fn == OP_ROT) begin
            model_cells[n-3] = b; model_cells[n-2] = t; model_top = a;
          end else begin
            model_cells[n-3] = t; model_cells[n-2] = a; model_top = b;
          end
        end
      end
      OP_PICK, OP_ROLL: begin
        if (n < 1 || t[31] || t >= 32'(n - 1)) e = ERR_UNDER;
        else begin
          idx = n - 2 - int'(t);
          model_top = model_cells[idx];
          if (w.fn == OP_ROLL) begin
            for (int i = idx; i + 2 < n; i++) model_cells[i] = model_cells[i+1];
            model_depth = n - 1;
          end
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_DIVMOD, OP_MIN, OP_MAX, OP_LT, OP_LE,
      OP_NE, OP_EQ, OP_GT, OP_GE, OP_AND, OP_OR, OP_XOR: begin
        if (n < 2) e = ERR_UNDER;
        else if ((w.fn == OP_DIV || w.fn == OP_MOD || w.fn == OP_DIVMOD) && t == 0)
          e = ERR_DIV0;
        else begin
          a = model_cells[n-2];
          trunc_divide(a, (t == 0) ? 32'd1 : t, q, r);
          if (w.fn == OP_DIVMOD) begin
            model_cells[n-2] = r;
            model_top = q;
          end else begin
            model_depth = n - 1;
            case (w.fn)
              OP_ADD: model_top = a + t;
              OP_SUB: model_top = a - t;
              OP_MUL: model_top = a * t;
              OP_DIV: model_top = q;
              OP_MOD: model_top = r;
              OP_MIN: model_top = sl(a, t) ? a : t;
              OP_MAX: model_top = sl(t, a) ? a : t;
              OP_LT:  model_top = truth(sl(a, t));
              OP_LE:  model_top = truth(!sl(t, a));
              OP_NE:  model_top = truth(a != t);
              OP_EQ:  model_top = truth(a == t);
              OP_GT:  model_top = truth(sl(t, a));
              OP_GE:  model_top = truth(!sl(a, t));
              OP_AND: model_top = a & t;
              OP_OR:  model_top = a | t;
              default: model_top = a ^ t;
            endcase
          end
        end
      end
      OP_INC1, OP_DEC1, OP_INC2, OP_DEC2, OP_SHL, OP_SHR, OP_INC4, OP_DEC4, OP_ABS,
      OP_NEG, OP_ZLT, OP_ZEQ, OP_ZGT, OP_NOT: begin
        if (n < 1) e = ERR_UNDER;
        else begin
          case (w.fn)
            OP_INC1: model_top = t + 1;
            OP_DEC1: model_top = t - 1;
            OP_INC2: model_top = t + 2;
            OP_DEC2: model_top = t - 2;
            OP_SHL:  model_top = t << 1;
            OP_SHR:  model_top = {t[31], t[31:1]};
            OP_INC4: model_top = t + 4;
            OP_DEC4: model_top = t - 4;
            OP_ABS:  model_top = t[31] ? -t : t;
            OP_NEG:  model_top = -t;
            OP_ZLT:  model_top = truth(t[31]);
            OP_ZEQ:  model_top = truth(t == 0);
            OP_ZGT:  model_top = truth(t != 0 && !t[31]);
            default: model_top = ~t;
          endcase
        end
      end
      default: ;
    endcase
    n = model_depth;
    v.top = (n >= 1) ? model_top : '0;
    v.second = (n >= 2) ? model_cells[n-2] : '0;
    v.items = 7'(n);
    v.error = e;
    return v;
  endfunction

  // driver
  always @(posedge clk) begin
    word_t w;
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_views.push_back(execute_word(pending_words.pop_front()));
        words_sent++;
      end
      if (start && busy) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap <= $urandom_range(0, 6);
        start <= 1'b0;
      end else if (pending_words.size() > (start && !busy ? 0 : 0) &&
                   pending_words.size() != 0) begin
        w = pending_words[0];
        start <= 1'b1;
        func <= w.fn;
        literal <= w.lit;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    stack_view_t x;
    if (!rst && done) begin
      views_seen++;
      if (expected_views.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected done: top=%h items=%0d", top, items);
      end else begin
        x = expected_views.pop_front();
        err_seen[x.error]++;
        if (top !== x.top || second !== x.second || items !== x.items ||
            error !== x.error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp top=%h second=%h items=%0d error=%0d, got %h %h %0d %0d",
                     x.top, x.second, x.items, x.error, top, second, items, error);
        end
      end
    end
  end

  function automatic logic [31:0] pick_literal();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0;
      4, 5: return $urandom_range(0, 6);
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_word(input logic [5:0] f, input logic [31:0] l = 32'h0);
    word_t w;
    w.fn = f;
    w.lit = l;
    pending_words.push_back(w);
  endfunction

  initial begin
    int sim_depth, r;
    logic [5:0] f;
    // directed: underflow on empty, extremes, division corner cases
    add_word(OP_DROP); add_word(OP_ADD); add_word(OP_PICK);
    add_word(OP_DEPTH); add_word(OP_QDUP); add_word(OP_DROP);
    add_word(OP_LIT, 32'h8000_0000); add_word(OP_LIT, 32'hFFFF_FFFF);
    add_word(OP_DIVMOD);
    add_word(OP_LIT, 32'h7FFF_FFFF); add_word(OP_LIT, 32'h0); add_word(OP_DIV);
    add_word(OP_MOD); add_word(OP_QDUP); add_word(OP_PICK);
    add_word(OP_LIT, 32'd1); add_word(OP_ROLL); add_word(OP_ROT); add_word(OP_NROT);
    add_word(OP_LIT, 32'hFFFF_FFFE); add_word(OP_PICK); add_word(6'd63);
    add_word(OP_ABS); add_word(OP_SHR);
    for (int i = 0; i < 70; i++) add_word(OP_DEPTH);
    add_word(OP_QDUP); add_word(OP_OVER); add_word(OP_LIT, 32'd63); add_word(OP_ROLL);
    add_word(OP_LIT, 32'd60); add_word(OP_PICK);
    for (int i = 0; i < 70; i++) add_word(OP_DROP);
    sim_depth = 0;
    // random: literals keep the stack populated and are often small, so many serve as indexes
    for (int i = 0; i < 1070; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30 || sim_depth < 2) begin
        add_word(OP_LIT, pick_literal()); sim_depth++;
      end else if (r < 40) begin
        add_word($urandom_range(0, 1) ? OP_PICK : OP_ROLL);
      end else if (r < 42) begin
        add_word(6'($urandom_range(42, 63)));
      end else begin
        f = 6'($urandom_range(1, 41));
        add_word(f);
        if (f == OP_DROP || (f >= OP_ADD && f <= OP_MOD) || (f >= OP_MIN && f <= OP_MAX) ||
            (f >= OP_LT && f <= OP_GE) || (f >= OP_AND && f <= OP_XOR)) sim_depth--;
        if (sim_depth > 30) sim_depth = 30;
      end
      if (sim_depth > 20 && $urandom_range(0, 3) == 0) begin
        add_word(OP_DROP); sim_depth--;
      end
      if (sim_depth < 0) sim_depth = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 60) @(posedge clk);
    quiet = 1'b1;
    while (pending_words.size() != 0 || expected_views.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d words sent, %0d results checked; error codes ok/under/over/div0: %0d/%0d/%0d/%0d",
             words_sent, views_seen, err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    wait (cycles >= 400000);
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/fdsa_pkg.sv
rtl/fdsa_cell.sv
rtl/fdsa_div.sv
rtl/forth_data_stack_alu.sv
tb/sv/forth_data_stack_alu_tb.sv
